// ===== design/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// types, constants and helper functions of the signed fixed-point alu
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 8;
  localparam int NUM_W     = WORD_W + FRAC_BITS;
  localparam int REM_W     = WORD_W + 1;
  localparam int ACT_W     = 4;

  localparam logic [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [63:0]       HALF = (64'd1 << FRAC_BITS) >> 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_INC      = 4'd4,
    ACT_DEC      = 4'd5,
    ACT_MIN      = 4'd6,
    ACT_MAX      = 4'd7,
    ACT_TO_INT   = 4'd8,
    ACT_FROM_INT = 4'd9
  } fpa_action_e;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [WORD_W-1:0] operand_a;
    logic signed [WORD_W-1:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic                     less_than;
    logic                     greater_than;
    logic                     equal_flag;
    logic                     overflow_flag;
    logic                     divide_by_zero;
  } fpa_out_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [WORD_W-1:0] res;
    logic              ovf;
    logic              dz;
    logic              lt;
    logic              gt;
    logic              eq;
    logic              neg;
  } fpa_side_t;

  typedef struct packed {
    fpa_side_t          side;
    logic signed [63:0] prod;
    logic [REM_W-1:0]   rem;
    logic [NUM_W-1:0]   num;
    logic [NUM_W-1:0]   quo;
    logic [WORD_W-1:0]  den;
  } fpa_cell_t;

  typedef struct packed {
    logic              ovf;
    logic [WORD_W-1:0] val;
  } fpa_sat_t;

  function automatic logic [63:0] mag_of(logic signed [WORD_W-1:0] v);
    logic signed [63:0] x;
    x = 64'(v);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic fpa_sat_t sat_mag(logic [63:0] m, logic neg);
    fpa_sat_t r;
    r.ovf = 1'b0;
    if (!neg) begin
      if (m > 64'(WMAX)) begin
        r.ovf = 1'b1;
        r.val = WMAX;
      end else begin
        r.val = m[WORD_W-1:0];
      end
    end else begin
      if (m > 64'(WMAX) + 64'd1) begin
        r.ovf = 1'b1;
        r.val = WMIN;
      end else begin
        r.val = WORD_W'(64'd0 - m);
      end
    end
    return r;
  endfunction

  function automatic fpa_sat_t sat_wide(logic [WORD_W:0] s);
    fpa_sat_t r;
    r.ovf = s[WORD_W] != s[WORD_W-1];
    if (r.ovf) begin
      r.val = s[WORD_W] ? WMIN : WMAX;
    end else begin
      r.val = s[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/fpa_div_cell.sv =====
// ----------------------------------------------------------------------------
// fpa_div_cell
// one restoring division step: shifts in a numerator bit, yields a quotient bit
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 en_i,
  input  wire                 valid_i,
  input  fpa_pkg::fpa_cell_t  data_i,
  output logic                valid_o,
  output fpa_pkg::fpa_cell_t  data_o
);
  import fpa_pkg::*;

  logic             valid_q;
  fpa_cell_t        data_q, data_d;
  logic [REM_W-1:0] trial;
  logic             fits;

  always_comb begin
    data_d = data_i;
    trial  = {data_i.rem[REM_W-2:0], data_i.num[NUM_W-1]};
    fits   = trial >= {1'b0, data_i.den};
    data_d.rem = fits ? (trial - {1'b0, data_i.den}) : trial;
    data_d.num = {data_i.num[NUM_W-2:0], 1'b0};
    data_d.quo = {data_i.quo[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== design/fixed_point_alu.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu
// signed fixed-point alu with saturation, rounding multiply and divide
// pipeline: entry stage, 40 divider cells, rounding/output stage
// throughput: one word per cycle unless stalled, set by the divider cell chain
// a stalled output freezes the whole pipeline
// reset clears all valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  fpa_pkg::fpa_in_t  in_data_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output fpa_pkg::fpa_out_t out_data_o
);
  import fpa_pkg::*;

  logic                     en;
  logic signed [WORD_W-1:0] a, b;
  fpa_side_t                side;
  fpa_sat_t                 st;
  logic signed [63:0]       prod;

  logic                     v0_q;
  fpa_cell_t                c0_q, c0_d;

  logic      vchain [NUM_W+1];
  fpa_cell_t cchain [NUM_W+1];

  fpa_cell_t   cl;
  logic [63:0] pm, mm, qd;
  fpa_sat_t    sm, sd;
  logic        out_valid_q;
  fpa_out_t    out_q, out_d;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  assign a = in_data_i.operand_a;
  assign b = in_data_i.operand_b;

  always_comb begin
    side.action = in_data_i.action;
    side.lt     = a < b;
    side.gt     = a > b;
    side.eq     = a == b;
    side.neg    = a[WORD_W-1] ^ b[WORD_W-1];
    side.res    = '0;
    side.ovf    = 1'b0;
    side.dz     = 1'b0;
    st          = '0;
    case (fpa_action_e'(in_data_i.action))
      ACT_ADD: begin
        st = sat_wide({a[WORD_W-1], a} + {b[WORD_W-1], b});
        side.res = st.val;
        side.ovf = st.ovf;
      end
      ACT_SUB: begin
        st = sat_wide({a[WORD_W-1], a} - {b[WORD_W-1], b});
        side.res = st.val;
        side.ovf = st.ovf;
      end
      ACT_INC: begin
        st = sat_wide({a[WORD_W-1], a} + (WORD_W+1)'(1));
        side.res = st.val;
        side.ovf = st.ovf;
      end
      ACT_DEC: begin
        st = sat_wide({a[WORD_W-1], a} - (WORD_W+1)'(1));
        side.res = st.val;
        side.ovf = st.ovf;
      end
      ACT_MIN: side.res = side.lt ? a : b;
      ACT_MAX: side.res = side.gt ? a : b;
      ACT_TO_INT: side.res = a >>> FRAC_BITS;
      ACT_FROM_INT: begin
        st = sat_mag(mag_of(a) << FRAC_BITS, a[WORD_W-1]);
        side.res = st.val;
        side.ovf = st.ovf;
      end
      ACT_DIV: begin
        if (b == '0) begin
          side.dz = 1'b1;
          if (a > 0) begin
            side.res = WMAX;
          end else if (a < 0) begin
            side.res = WMIN;
          end
        end
      end
      default: side.res = '0;
    endcase
  end

  always_comb begin
    prod      = a * b;
    c0_d.side = side;
    c0_d.prod = prod;
    c0_d.rem  = '0;
    c0_d.num  = NUM_W'(mag_of(a) << FRAC_BITS);
    c0_d.quo  = '0;
    c0_d.den  = WORD_W'(mag_of(b));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_q <= c0_d;
    end
  end

  assign vchain[0] = v0_q;
  assign cchain[0] = c0_q;

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vchain[i]),
      .data_i  (cchain[i]),
      .valid_o (vchain[i+1]),
      .data_o  (cchain[i+1])
    );
  end

  // rounding, sign and saturation of product and quotient
  always_comb begin
    cl = cchain[NUM_W];
    pm = (cl.prod < 0) ? 64'(-cl.prod) : 64'(cl.prod);
    mm = (pm + HALF) >> FRAC_BITS;
    sm = sat_mag(mm, cl.prod < 0);
    qd = 64'(cl.quo) + 64'({cl.rem, 1'b0} >= {2'b0, cl.den});
    sd = sat_mag(qd, cl.side.neg);
    out_d.result_value   = cl.side.res;
    out_d.overflow_flag  = cl.side.ovf;
    out_d.divide_by_zero = cl.side.dz;
    out_d.less_than      = cl.side.lt;
    out_d.greater_than   = cl.side.gt;
    out_d.equal_flag     = cl.side.eq;
    if (cl.side.action == ACT_MUL) begin
      out_d.result_value  = sm.val;
      out_d.overflow_flag = sm.ovf;
    end else if (cl.side.action == ACT_DIV && !cl.side.dz) begin
      out_d.result_value  = sd.val;
      out_d.overflow_flag = sd.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vchain[NUM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_one_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({out_data_o.less_than, out_data_o.greater_than,
                                out_data_o.equal_flag}) == 1)
    else $error("compare flags not exclusive");

  a_dz_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.divide_by_zero && out_data_o.overflow_flag))
    else $error("divide by zero with overflow");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vchain[0]) && $stable(vchain[NUM_W]))
    else $error("pipeline moved while frozen");

endmodule

`default_nettype wire

// ===== tb/fixed_point_alu_checker.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_checker
// watches both channels of the fixed-point alu, predicts each result word
// from the accepted input word and compares them in order, showing each field
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_checker (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_stall_i,
  input  fpa_pkg::fpa_in_t  in_data_i,
  input  wire               out_valid_i,
  input  wire               out_stall_i,
  input  fpa_pkg::fpa_out_t out_data_i,
  output int                fail_count_o,
  output int                pending_count_o
);
  import fpa_pkg::*;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  fpa_out_t expected_q[$];

  function automatic longint clamp(longint v, ref logic ovf);
    if (v > SAT_HI) begin
      ovf = 1'b1;
      return SAT_HI;
    end
    if (v < SAT_LO) begin
      ovf = 1'b1;
      return SAT_LO;
    end
    return v;
  endfunction

  function automatic fpa_out_t alu_result(fpa_in_t w);
    fpa_out_t   o;
    longint     a, b, r, p;
    logic [63:0] m, n, d, q, rm;
    logic       ovf;
    a = longint'(w.operand_a);
    b = longint'(w.operand_b);
    r = 0;
    ovf = 1'b0;
    o = '0;
    case (w.action)
      ACT_ADD: r = clamp(a + b, ovf);
      ACT_SUB: r = clamp(a - b, ovf);
      ACT_MUL: begin
        p = a * b;
        m = (p < 0) ? 64'(-p) : 64'(p);
        q = (m + HALF) >> FRAC_BITS;
        r = clamp((p < 0) ? -longint'(q) : longint'(q), ovf);
      end
      ACT_DIV: begin
        if (b == 0) begin
          o.divide_by_zero = 1'b1;
          r = (a > 0) ? SAT_HI : ((a < 0) ? SAT_LO : 0);
        end else begin
          n = ((a < 0) ? 64'(-a) : 64'(a)) << FRAC_BITS;
          d = (b < 0) ? 64'(-b) : 64'(b);
          q = n / d;
          rm = n % d;
          if (rm >= d - rm) q = q + 1;
          r = clamp(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q), ovf);
        end
      end
      ACT_INC: r = clamp(a + 1, ovf);
      ACT_DEC: r = clamp(a - 1, ovf);
      ACT_MIN: r = (a < b) ? a : b;
      ACT_MAX: r = (a > b) ? a : b;
      ACT_TO_INT: r = a >>> FRAC_BITS;
      ACT_FROM_INT: begin
        m = ((a < 0) ? 64'(-a) : 64'(a)) << FRAC_BITS;
        r = clamp((a < 0) ? -longint'(m) : longint'(m), ovf);
      end
      default: r = 0;
    endcase
    o.result_value = r[31:0];
    o.less_than = a < b;
    o.greater_than = a > b;
    o.equal_flag = a == b;
    o.overflow_flag = ovf;
    return o;
  endfunction

  assign pending_count_o = expected_q.size();

  always @(posedge clk_i) begin
    fpa_out_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) expected_q.push_back(alu_result(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected word %h", out_data_i);
        end else begin
          want = expected_q.pop_front();
          if (want !== out_data_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display({"mismatch: expected val %h lt %b gt %b eq %b ovf %b dz %b,",
                        " got val %h lt %b gt %b eq %b ovf %b dz %b"},
                       want.result_value, want.less_than, want.greater_than,
                       want.equal_flag, want.overflow_flag, want.divide_by_zero,
                       out_data_i.result_value, out_data_i.less_than,
                       out_data_i.greater_than, out_data_i.equal_flag,
                       out_data_i.overflow_flag, out_data_i.divide_by_zero);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/fixed_point_alu_test.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_test
// drives directed and random words into the fixed-point alu under varying
// idle patterns and a long output hold-off; the checker judges every result
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_test;
  import fpa_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  fpa_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  fpa_out_t out_data;
  int       fail_count, pending_count;
  int       send_idle_pct = 29, recv_idle_pct = 79;
  logic     hold_off = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fixed_point_alu uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  fixed_point_alu_checker check (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(4)) - 32'd2;
      3: return 32'($signed($urandom_range(65535)) - 32768);
      4: return 32'($signed($urandom_range(2047)) - 1024) << 8;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(logic [3:0] act, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{action: act, operand_a: a, operand_b: b};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    logic [3:0] act;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                      : 4'($urandom_range(9));
      send_word(act, pick_operand(), ($urandom_range(15) == 0) ? 32'd0 : pick_operand());
    end
  endtask

  initial begin
    logic [31:0] edges[6];
    edges = '{32'h7fffffff, 32'h80000000, 32'd0, 32'd1, 32'hffffffff, 32'h00000100};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int k = 0; k < 10; k++) send_word(4'(k), edges[k % 6], edges[(k + 1) % 6]);
    send_word(ACT_DIV, 32'h00000500, 32'd0);
    send_word(ACT_DIV, 32'hfffffb00, 32'd0);
    send_word(ACT_DIV, 32'd0, 32'd0);
    send_word(ACT_DIV, 32'h00000100, 32'h00000300);
    send_word(ACT_MUL, 32'h00000080, 32'h00000001);
    send_word(ACT_MUL, 32'hffffff80, 32'h00000001);
    send_word(ACT_INC, 32'h7fffffff, 32'h7fffffff);
    send_word(ACT_DEC, 32'h80000000, 32'h80000000);
    send_word(ACT_TO_INT, 32'hffffff01, 32'd5);
    send_word(ACT_FROM_INT, 32'h00800000, 32'd0);
    send_word(ACT_FROM_INT, 32'hff800000, 32'd0);
    send_word(4'd15, 32'd7, 32'd7);
    send_word(4'd10, 32'd3, 32'd9);
    send_random(600);
    send_idle_pct = 79;
    recv_idle_pct = 29;
    send_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off <= 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off <= 1'b0;
      end
      send_random(130);
    join
    send_random(600);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
